>>> sv/battery_led_indicator_macros.svh
// assertion macros for the battery led indicator
`ifndef BATTERY_LED_INDICATOR_MACROS_SVH
`define BATTERY_LED_INDICATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define BLI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("battery_led_indicator assertion failed");

// next-cycle implication, checked out of reset
`define BLI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("battery_led_indicator assertion failed");

`endif

>>> sv/bli_pkg.sv
// shared types and constants for the battery led indicator
`default_nettype none

package bli_pkg;

    localparam int PHASE_W = 6;
    localparam int BLINK_W = 2;
    localparam int PRESS_W = 8;
    localparam int MV_W    = 16;

    localparam logic [PHASE_W-1:0] BUTTON_PHASE_LOAD = 6'd9;
    localparam logic [PRESS_W-1:0] READ_AT_TICKS     = 8'd40;
    localparam logic [PRESS_W-1:0] STORE_AT_TICKS    = 8'd45;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VERY_LOW_THRESHOLD = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CRIT_THRESHOLD     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_ENABLE      = 8'd3;

    localparam logic [MV_W-1:0] LOW_THRESHOLD_RST      = 16'd3600;
    localparam logic [MV_W-1:0] VERY_LOW_THRESHOLD_RST = 16'd3500;
    localparam logic [MV_W-1:0] CRIT_THRESHOLD_RST     = 16'd3400;

    typedef struct packed {
        logic [MV_W-1:0] low_threshold_mv;
        logic [MV_W-1:0] very_low_threshold_mv;
        logic [MV_W-1:0] critical_threshold_mv;
        logic            button_enable;
    } cfg_t;

    typedef struct packed {
        logic request_store_state;
        logic request_battery_read;
        logic led_lit;
    } result_t;

endpackage

`default_nettype wire

>>> sv/bli_step.sv
// tick state registers and the per-tick led and request logic
`default_nettype none

module bli_step
    import bli_pkg::*;
#(
    parameter int PERIOD_TICKS = 40
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic            button_level,
    input  wire logic [MV_W-1:0] battery_mv,
    input  wire cfg_t            cfg,
    output result_t              result
);

    logic [PHASE_W-1:0] phase_count_reg, phase_count_next;
    logic [BLINK_W-1:0] blinks_left_reg, blinks_left_next;
    logic               last_button_reg, last_button_next;
    logic [PRESS_W-1:0] press_ticks_reg, press_ticks_next;
    logic               led_state_reg, led_state_next;

    logic               changed;
    logic               held;
    logic [PHASE_W-1:0] phase_a;
    logic [PHASE_W-1:0] phase_inc;
    logic [PRESS_W-1:0] press_a;
    logic               led_a;
    logic [BLINK_W-1:0] blinks_a;
    logic [BLINK_W-1:0] blink_load;

    always_comb
    begin
        changed = cfg.button_enable && (button_level != last_button_reg);
        held    = cfg.button_enable && !button_level;

        phase_a = changed ? BUTTON_PHASE_LOAD : phase_count_reg;
        press_a = changed ? '0 : press_ticks_reg;
        led_a   = changed ? !button_level : led_state_reg;

        last_button_next = cfg.button_enable ? button_level : last_button_reg;
        press_ticks_next = held ? press_a + 1'b1 : press_a;

        blink_load = BLINK_W'(battery_mv < cfg.low_threshold_mv)
                   + BLINK_W'(battery_mv < cfg.very_low_threshold_mv)
                   + BLINK_W'(battery_mv < cfg.critical_threshold_mv);
        blinks_a   = (phase_a == '0) ? blink_load : blinks_left_reg;

        // 6-bit increment wraps at 64, then the period check
        phase_inc = phase_a + 1'b1;
        if (phase_inc >= PHASE_W'(PERIOD_TICKS))
        begin
            phase_inc = '0;
        end

        result.request_battery_read = held && (press_ticks_next == READ_AT_TICKS);
        result.request_store_state  = held && (press_ticks_next == STORE_AT_TICKS);

        if (held)
        begin
            // toggle on the counts strictly between read and store
            led_state_next   = led_a ^ ((press_ticks_next > READ_AT_TICKS) &&
                                        (press_ticks_next < STORE_AT_TICKS));
            phase_count_next = phase_a;
            blinks_left_next = blinks_left_reg;
        end
        else
        begin
            led_state_next   = led_a;
            blinks_left_next = blinks_a;
            if (blinks_a != '0)
            begin
                if (!phase_a[0])
                begin
                    led_state_next = 1'b1;
                end
                else
                begin
                    led_state_next   = 1'b0;
                    blinks_left_next = blinks_a - 1'b1;
                end
            end
            phase_count_next = phase_inc;
        end

        result.led_lit = led_state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_count_reg <= '0;
            blinks_left_reg <= '0;
            last_button_reg <= 1'b0;
            press_ticks_reg <= '0;
            led_state_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_count_reg <= phase_count_next;
            blinks_left_reg <= blinks_left_next;
            last_button_reg <= last_button_next;
            press_ticks_reg <= press_ticks_next;
            led_state_reg   <= led_state_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/bli_out_buf.sv
// result register with a skid stage so input takes one more word under output stall
`default_nettype none

module bli_out_buf
    import bli_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire result_t in_word,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_word
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_word_reg, out_word_next;
    result_t skid_word_reg, skid_word_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_word_next  = in_word;
            end
        end
        else if (in_valid && !skid_valid_reg)
        begin
            // output slot is stalled, park the word
            skid_valid_next = 1'b1;
            skid_word_next  = in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

endmodule

`default_nettype wire

>>> sv/battery_led_indicator.sv
// a tick word's result is registered in the result register, or skid stage under stall
// throughput: one tick word per cycle while the skid stage is empty
// a skid stage keeps s_tready high for one more word while m_tready is low
// reset: async active low, clears tick state, thresholds to 3600/3500/3400 mv,
// button handling enabled, no result word pending
`default_nettype none

`include "battery_led_indicator_macros.svh"

module battery_led_indicator
    import bli_pkg::*;
#(
    parameter int PERIOD_TICKS = 40
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [23:0]            s_tdata,   // button_level, battery_mv, zero pad
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [7:0]                  m_tdata,   // led_lit, request_battery_read,
                                                   // request_store_state, zero pad
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    result_t step_result;
    result_t out_word;
    logic    accept;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_threshold_mv      <= LOW_THRESHOLD_RST;
            cfg_reg.very_low_threshold_mv <= VERY_LOW_THRESHOLD_RST;
            cfg_reg.critical_threshold_mv <= CRIT_THRESHOLD_RST;
            cfg_reg.button_enable         <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LOW_THRESHOLD:      cfg_reg.low_threshold_mv      <= cfg_data;
                REG_VERY_LOW_THRESHOLD: cfg_reg.very_low_threshold_mv <= cfg_data;
                REG_CRIT_THRESHOLD:     cfg_reg.critical_threshold_mv <= cfg_data;
                REG_BUTTON_ENABLE:      cfg_reg.button_enable         <= cfg_data[0];
                default: ;
            endcase
        end
    end

    bli_step #(
        .PERIOD_TICKS (PERIOD_TICKS)
    ) u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .button_level (s_tdata[0]),
        .battery_mv   (s_tdata[MV_W:1]),
        .cfg          (cfg_reg),
        .result       (step_result)
    );

    bli_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (step_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = {5'b0, out_word.request_store_state,
                      out_word.request_battery_read, out_word.led_lit};

    `BLI_ASSERT_NOW(a_no_dual_request, m_tvalid, !(m_tdata[1] && m_tdata[2]))
    `BLI_ASSERT_NOW(a_stall_needs_word, !s_tready, m_tvalid)
    `BLI_ASSERT_NOW(a_no_request_when_off, m_tvalid && !cfg_reg.button_enable, m_tdata[2:1] == 2'b00)
    `BLI_ASSERT_NEXT(a_accept_gives_word, accept, m_tvalid)

endmodule

`default_nettype wire

>>> sim/tb_battery_led_indicator.sv
// self-checking testbench for the battery led indicator: tick stream, config writes, led and request checks
module tb_battery_led_indicator
    import bli_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PERIOD = 40;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = REG_BUTTON_ENABLE + 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LAST  = 8'hFF;

    class led_tick_scoreboard;
        logic [MV_W-1:0]    low_mv;
        logic [MV_W-1:0]    very_low_mv;
        logic [MV_W-1:0]    crit_mv;
        bit                 btn_en;
        logic [PHASE_W-1:0] phase;
        logic [BLINK_W-1:0] blinks;
        bit                 last_btn;
        logic [PRESS_W-1:0] press;
        bit                 led;
        result_t            due_results[$];
        int                 errors;

        function new();
            low_mv      = LOW_THRESHOLD_RST;
            very_low_mv = VERY_LOW_THRESHOLD_RST;
            crit_mv     = CRIT_THRESHOLD_RST;
            btn_en      = 1'b1;
            phase       = '0;
            blinks      = '0;
            last_btn    = 1'b0;
            press       = '0;
            led         = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LOW_THRESHOLD:      low_mv      = data;
                REG_VERY_LOW_THRESHOLD: very_low_mv = data;
                REG_CRIT_THRESHOLD:     crit_mv     = data;
                REG_BUTTON_ENABLE:      btn_en      = data[0];
                default: ;
            endcase
        endfunction

        // advance the led state by one tick and queue the word it should produce
        function void advance_tick(bit lvl, logic [MV_W-1:0] mv);
            bit      held;
            result_t r;
            int      n;
            held = 1'b0;
            r    = '0;
            if (btn_en)
            begin
                if (lvl != last_btn)
                begin
                    press    = '0;
                    led      = !lvl;
                    last_btn = lvl;
                    phase    = BUTTON_PHASE_LOAD;
                end
                if (!lvl)
                begin
                    held  = 1'b1;
                    press = press + 8'd1;
                    if (press == READ_AT_TICKS)
                        r.request_battery_read = 1'b1;
                    if (press == STORE_AT_TICKS)
                        r.request_store_state = 1'b1;
                    if (press > READ_AT_TICKS && press < STORE_AT_TICKS)
                        led = !led;
                end
            end
            if (!held)
            begin
                if (phase == '0)
                begin
                    n = 0;
                    if (mv < low_mv)
                        n++;
                    if (mv < very_low_mv)
                        n++;
                    if (mv < crit_mv)
                        n++;
                    blinks = n[BLINK_W-1:0];
                end
                if (blinks != '0)
                begin
                    if (!phase[0])
                        led = 1'b1;
                    else
                    begin
                        led    = 1'b0;
                        blinks = blinks - 2'd1;
                    end
                end
                phase = phase + 6'd1;
                if (phase >= PERIOD)
                    phase = '0;
            end
            r.led_lit = led;
            due_results.push_back(r);
        endfunction

        function void check_led_word(logic [7:0] word);
            result_t want;
            if (due_results.size() == 0)
            begin
                $error("result word %h arrived with nothing outstanding", word);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (word[0] !== want.led_lit)
            begin
                $error("led_lit expected %0b actual %0b", want.led_lit, word[0]);
                errors++;
            end
            if (word[1] !== want.request_battery_read)
            begin
                $error("request_battery_read expected %0b actual %0b",
                       want.request_battery_read, word[1]);
                errors++;
            end
            if (word[2] !== want.request_store_state)
            begin
                $error("request_store_state expected %0b actual %0b",
                       want.request_store_state, word[2]);
                errors++;
            end
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [23:0]            s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int src_idle_pct  = 0;
    int dst_stall_pct = 0;

    led_tick_scoreboard sb = new();

    battery_led_indicator #(.PERIOD_TICKS(PERIOD)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= dst_stall_pct);

    // results are checked before the tick of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_led_word(m_tdata);
            if (s_tvalid && s_tready)
                sb.advance_tick(s_tdata[0], s_tdata[16:1]);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    initial
    begin
        #5ms;
        $display("tb_battery_led_indicator failed");
        $finish;
    end

    task automatic send_tick(bit lvl, logic [MV_W-1:0] mv);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, mv, lvl};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic stop_ticks();
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // one result per tick, so an empty queue means the block is idle
    task automatic wait_drained();
        stop_ticks();
        while (sb.due_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [MV_W-1:0] pick_mv();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        else if (sel < 25)
            return sb.low_mv + 16'($urandom_range(4)) - 16'd2;
        else if (sel < 35)
            return sb.very_low_mv + 16'($urandom_range(4)) - 16'd2;
        else if (sel < 45)
            return sb.crit_mv + 16'($urandom_range(4)) - 16'd2;
        else
            return 16'($urandom_range(16'hFFFF));
    endfunction

    // released runs long enough to reach the blink load, holds that cross read and store
    task automatic stream_ticks(int count);
        int left;
        int seg;
        int sel;
        bit lvl;
        bit noisy;
        left = count;
        while (left > 0)
        begin
            sel   = $urandom_range(99);
            noisy = 1'b0;
            if (sel < 45)
            begin
                lvl = 1'b1;
                seg = $urandom_range(1, 90);
            end
            else if (sel < 85)
            begin
                lvl = 1'b0;
                seg = $urandom_range(1, 55);
            end
            else
            begin
                noisy = 1'b1;
                seg   = $urandom_range(1, 10);
            end
            if (seg > left)
                seg = left;
            repeat (seg)
            begin
                send_tick(noisy ? 1'($urandom_range(1)) : lvl, pick_mv());
                left--;
            end
        end
    endtask

    task automatic random_thresholds();
        set_reg(REG_LOW_THRESHOLD, 16'($urandom_range(3000, 4200)));
        set_reg(REG_VERY_LOW_THRESHOLD, 16'($urandom_range(16'hFFFF)));
        set_reg(REG_CRIT_THRESHOLD, 16'($urandom_range(2800, 3800)));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values, no idling; the first released tick counts as a change
        send_tick(1'b1, 16'hFFFF);
        send_tick(1'b1, 16'h0000);
        send_tick(1'b1, 16'd3399);
        send_tick(1'b1, 16'd3400);
        send_tick(1'b1, 16'd3499);
        send_tick(1'b1, 16'd3500);
        send_tick(1'b1, 16'd3599);
        send_tick(1'b1, 16'd3600);
        repeat (3) send_tick(1'b0, 16'h0000);
        send_tick(1'b1, 16'hFFFF);
        send_tick(1'b0, 16'h5555);
        send_tick(1'b1, 16'hAAAA);
        send_tick(1'b0, 16'hFFFF);
        send_tick(1'b0, 16'h0000);
        send_tick(1'b1, 16'd3401);
        stream_ticks(150);
        wait_drained();

        // top thresholds, sender mostly idle, a full drain midway
        set_reg(REG_LOW_THRESHOLD, 16'hFFFF);
        set_reg(REG_VERY_LOW_THRESHOLD, 16'hFFFF);
        set_reg(REG_CRIT_THRESHOLD, 16'hFFFF);
        src_idle_pct = 85;
        stream_ticks(60);
        wait_drained();
        stream_ticks(70);
        wait_drained();

        // zero thresholds then a low threshold of 3700, button ignored, receiver mostly stalled
        set_reg(REG_LOW_THRESHOLD, 16'h0000);
        set_reg(REG_VERY_LOW_THRESHOLD, 16'h0000);
        set_reg(REG_CRIT_THRESHOLD, 16'h0000);
        set_reg(REG_BUTTON_ENABLE, {15'($urandom), 1'b0});
        src_idle_pct  = 0;
        dst_stall_pct = 85;
        stream_ticks(60);
        wait_drained();
        set_reg(REG_LOW_THRESHOLD, 16'd3700);
        stream_ticks(70);
        wait_drained();

        // long hold wraps the press counter; writes past the last register do nothing
        set_reg(REG_BUTTON_ENABLE, {15'($urandom), 1'b1});
        set_reg(REG_UNUSED_FIRST, 16'($urandom));
        set_reg(REG_UNUSED_LAST, 16'($urandom));
        set_reg(8'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)), 16'($urandom));
        random_thresholds();
        src_idle_pct  = 25;
        dst_stall_pct = 25;
        send_tick(1'b1, pick_mv());
        repeat (300) send_tick(1'b0, pick_mv());
        stream_ticks(80);
        wait_drained();

        // random thresholds in any order, no idling
        random_thresholds();
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        stream_ticks(130);
        wait_drained();

        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("tb_battery_led_indicator passed");
        else
            $display("tb_battery_led_indicator failed");
        $finish;
    end

endmodule
